### rtl/vclru_pkg.sv
// ----------------------------------------------------------------------------
// vclru_pkg
// Shared types and constants for the LRU vertex cache lookup block.
// ----------------------------------------------------------------------------
package vclru_pkg;

  localparam int unsigned TagW   = 32;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotW  = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_REDUCE,
    ST_COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_key;
    logic look;
    logic reduce;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic miss_full;
    logic reduce_last;
    logic out_free;
  } status_t;

endpackage

### rtl/vclru_ctrl.sv
// ----------------------------------------------------------------------------
// vclru_ctrl
// Sequencer for the vertex cache: lookup, optional LRU reduction, commit.
// ----------------------------------------------------------------------------
module vclru_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vclru_pkg::status_t status,
  output vclru_pkg::cmd_t    cmd
);

  vclru_pkg::state_t state;
  vclru_pkg::state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vclru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd          = '0;
    unique case (state)
      vclru_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_next   = vclru_pkg::ST_LOOK;
        end
      end
      vclru_pkg::ST_LOOK: begin
        cmd.look = 1'b1;
        if (status.miss_full) begin
          state_next = vclru_pkg::ST_REDUCE;
        end else begin
          state_next = vclru_pkg::ST_COMMIT;
        end
      end
      vclru_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (status.reduce_last) begin
          state_next = vclru_pkg::ST_COMMIT;
        end
      end
      vclru_pkg::ST_COMMIT: begin
        // Commit once the output register can take the beat; take the next item alongside
        if (status.out_free) begin
          cmd.commit = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.load_key = 1'b1;
            state_next   = vclru_pkg::ST_LOOK;
          end else begin
            state_next   = vclru_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = vclru_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/vclru_dp.sv
// ----------------------------------------------------------------------------
// vclru_dp
// Entry storage, parallel tag compare, registered min-stamp tree and
// output register of the vertex cache.
// ----------------------------------------------------------------------------
module vclru_dp #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vclru_pkg::cmd_t               cmd,
  input  logic [vclru_pkg::TagW-1:0]    vertex_index,
  input  logic                          out_stall,
  output vclru_pkg::status_t            status,
  output logic                          out_valid,
  output logic                          hit,
  output logic [vclru_pkg::SlotW-1:0]   slot
);

  localparam int unsigned IW   = $clog2(CACHE_ENTRIES);
  localparam int unsigned CW   = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned P    = 1 << IW;
  localparam int unsigned HP   = P / 2;
  localparam int unsigned SW   = $clog2(IW + 1);
  localparam int unsigned TagW = vclru_pkg::TagW;
  localparam int unsigned StW  = vclru_pkg::StampW;

  // Entry storage, undefined until written
  logic [TagW-1:0] tag   [CACHE_ENTRIES];
  logic [StW-1:0]  stamp [CACHE_ENTRIES];

  logic [CW-1:0]   count;
  logic [StW-1:0]  fetch;
  logic [TagW-1:0] key;

  // Lookup result
  logic            lk_hit;
  logic [IW-1:0]   lk_slot;
  logic            need_reduce;

  // Reduction tree working set
  logic [StW-1:0]  red_stamp [P];
  logic [IW-1:0]   red_idx   [P];
  logic            red_vld   [P];
  logic [SW-1:0]   step;

  logic [CACHE_ENTRIES-1:0] match;
  logic            any_match;
  logic [IW-1:0]   match_idx;
  logic            full;

  logic [StW-1:0]  leaf_stamp [P];
  logic            leaf_vld   [P];

  logic [StW-1:0]  half_stamp [HP];
  logic [IW-1:0]   half_idx   [HP];
  logic            half_vld   [HP];

  logic [IW-1:0]   slot_sel;
  logic [IW+vclru_pkg::SlotW-1:0] slot_ext;

  // Compare the key against every filled entry
  always_comb begin
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      match[k] = (CW'(k) < count) && (tag[k] == key);
    end
  end

  // Pick the lowest matching slot
  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        any_match = 1'b1;
        match_idx = IW'(k);
      end
    end
  end

  assign full = (count == CW'(CACHE_ENTRIES));

  // Leaves of the tree; padding leaves never win
  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < CACHE_ENTRIES) begin : g_real
      assign leaf_stamp[g] = stamp[g];
      assign leaf_vld[g]   = 1'b1;
    end else begin : g_pad
      assign leaf_stamp[g] = '0;
      assign leaf_vld[g]   = 1'b0;
    end
  end

  // One tree level: keep the smaller stamp, the lower slot on a tie
  always_comb begin
    for (int i = 0; i < HP; i++) begin
      if (red_vld[2*i+1] && (!red_vld[2*i] || (red_stamp[2*i+1] < red_stamp[2*i]))) begin
        half_stamp[i] = red_stamp[2*i+1];
        half_idx[i]   = red_idx[2*i+1];
        half_vld[i]   = red_vld[2*i+1];
      end else begin
        half_stamp[i] = red_stamp[2*i];
        half_idx[i]   = red_idx[2*i];
        half_vld[i]   = red_vld[2*i];
      end
    end
  end

  // Latch the key on an accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= vertex_index;
    end
  end

  // Register lookup result and load the tree
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      lk_hit      <= any_match;
      lk_slot     <= any_match ? match_idx : count[IW-1:0];
      need_reduce <= !any_match && full;
      step        <= SW'(IW);
      for (int i = 0; i < P; i++) begin
        red_stamp[i] <= leaf_stamp[i];
        red_vld[i]   <= leaf_vld[i];
        red_idx[i]   <= IW'(i);
      end
    end else if (cmd.reduce) begin
      step <= step - SW'(1);
      for (int i = 0; i < HP; i++) begin
        red_stamp[i] <= half_stamp[i];
        red_idx[i]   <= half_idx[i];
        red_vld[i]   <= half_vld[i];
      end
    end
  end

  assign slot_sel = need_reduce ? red_idx[0] : lk_slot;
  assign slot_ext = (IW + vclru_pkg::SlotW)'(slot_sel);

  // Write the entry on commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      stamp[slot_sel] <= fetch;
      if (!lk_hit) begin
        tag[slot_sel] <= key;
      end
    end
  end

  // Advance fill count and fetch counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fetch <= '0;
    end else if (cmd.commit) begin
      fetch <= fetch + StW'(1);
      if (!lk_hit && !need_reduce) begin
        count <= count + CW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit  <= lk_hit;
      slot <= slot_ext[vclru_pkg::SlotW-1:0];
    end
  end

  assign status.miss_full   = !any_match && full;
  assign status.reduce_last = (step == SW'(1));
  assign status.out_free    = !out_valid || !out_stall;

endmodule

### rtl/vertex_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// vertex_cache_lru_lookup
// Fully associative post-transform vertex cache with LRU replacement.
// ----------------------------------------------------------------------------
// Flow: an accepted beat is held in the lookup state, then the commit state writes
//   the entry and loads the output register; on a replacement the reduction state
//   walks the min-stamp tree one level per cycle between lookup and commit. While
//   busy, a new item is taken only alongside the commit, which waits on a stalled output.
// Reset (synchronous): clears the sequencer, fill count, fetch counter and
//   output valid; entry tags and stamps stay unknown and need no clearing pass.
module vertex_cache_lru_lookup #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [vclru_pkg::TagW-1:0]  vertex_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [vclru_pkg::SlotW-1:0] slot
);

  vclru_pkg::cmd_t    cmd;
  vclru_pkg::status_t status;

  vclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vclru_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .vertex_index (vertex_index),
    .out_stall    (out_stall),
    .status       (status),
    .out_valid    (out_valid),
    .hit          (hit),
    .slot         (slot)
  );

endmodule

### rtl/vclru_chk.sv
// ----------------------------------------------------------------------------
// vclru_chk
// Port-level checks for the vertex cache, bound to the top level.
// ----------------------------------------------------------------------------
module vclru_chk #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        hit,
  input logic [vclru_pkg::SlotW-1:0] slot
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(slot))
    else $error("stalled result beat changed");

  // The input is stalled in the cycle after an accepted beat, during the lookup
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in the lookup cycle");

  // A new result only rises after a commit, which also opens the input
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_stall))
    else $error("result appeared outside a commit");

  // Slot stays inside the cache when it has at most 16 entries
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CACHE_ENTRIES > 16) || (slot < CACHE_ENTRIES))
    else $error("slot beyond cache size");

endmodule

bind vertex_cache_lru_lookup vclru_chk #(
  .CACHE_ENTRIES (CACHE_ENTRIES)
) u_vclru_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .slot      (slot)
);
